// ===== src/aubt_pkg.sv =====
// ----------------------------------------------------------------------------
// aubt_pkg: shared types and constants of the access unit boundary tracker
// Packet and result payloads, codes, controller states and command structs.
// ----------------------------------------------------------------------------
package aubt_pkg;

	localparam int MAX_STREAMS = 8;
	localparam int IDX_W       = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int CNT_W       = $clog2(MAX_STREAMS + 1);
	localparam int LABEL_W     = 10;
	localparam int RATE_W      = 24;
	localparam int FSZ_W       = 16;
	localparam int PROF_W      = 8;
	localparam int TCNT_W      = 13;
	localparam int TSUM_W      = 17;

	localparam logic [PROF_W-1:0] PROFILE_LOW  = 8'h0B;
	localparam logic [PROF_W-1:0] PROFILE_HIGH = 8'h14;
	localparam logic [TSUM_W-1:0] TRUNC_MAX    = 17'h1FFFF;

	// packet kinds
	localparam logic [2:0] KIND_SYNC   = 3'd0;
	localparam logic [2:0] KIND_CONFIG = 3'd1;
	localparam logic [2:0] KIND_FRAME  = 3'd2;
	localparam logic [2:0] KIND_TRUNC  = 3'd3;

	// verdicts
	localparam logic [1:0] VERD_APPEND  = 2'd0;
	localparam logic [1:0] VERD_BEFORE  = 2'd1;
	localparam logic [1:0] VERD_AFTER   = 2'd2;
	localparam logic [1:0] VERD_DISCARD = 2'd3;

	// violations
	localparam logic [1:0] VIOL_NONE   = 2'd0;
	localparam logic [1:0] VIOL_DUP    = 2'd1;
	localparam logic [1:0] VIOL_NOCFG  = 2'd2;
	localparam logic [1:0] VIOL_REPEAT = 2'd3;

	// unit errors
	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_IPF      = 3'd1;
	localparam logic [2:0] ERR_TIMING   = 3'd2;
	localparam logic [2:0] ERR_TRUNC    = 3'd3;
	localparam logic [2:0] ERR_PROFILE  = 3'd4;
	localparam logic [2:0] ERR_NOCONFIG = 3'd5;

	typedef struct packed {
		logic [2:0]         packet_kind;
		logic [LABEL_W-1:0] packet_label;
		logic [RATE_W-1:0]  cfg_sample_rate;
		logic [FSZ_W-1:0]   cfg_frame_size;
		logic [PROF_W-1:0]  cfg_profile;
		logic               frame_ipf;
		logic               trunc_active;
		logic [TCNT_W-1:0]  trunc_count;
	} pkt_t;

	typedef struct packed {
		logic [1:0]        verdict;
		logic              last;
		logic [1:0]        violation;
		logic              fatal;
		logic [RATE_W-1:0] unit_rate;
		logic [FSZ_W-1:0]  unit_duration;
		logic              unit_ipf;
		logic [2:0]        unit_error;
	} res_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_COMMIT,
		ST_REP_BEFORE,
		ST_REP_AFTER,
		ST_OUT
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic apply;
		logic commit;
		logic report;
		logic early;
	} cmd_t;

	typedef struct packed {
		logic close_before;
		logic close_after;
	} stat_t;

endpackage

// ===== src/aubt_pkt_if.sv =====
// ----------------------------------------------------------------------------
// aubt_pkt_if: packet descriptor channel
// Valid/ready channel carrying one packet descriptor per beat.
// ----------------------------------------------------------------------------
interface aubt_pkt_if import aubt_pkg::*; ();
	logic valid;
	logic ready;
	pkt_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/aubt_res_if.sv =====
// ----------------------------------------------------------------------------
// aubt_res_if: result channel
// Valid/ready channel carrying one result item per beat.
// ----------------------------------------------------------------------------
interface aubt_res_if import aubt_pkg::*; ();
	logic valid;
	logic ready;
	res_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/aubt_cfg_if.sv =====
// ----------------------------------------------------------------------------
// aubt_cfg_if: configuration write channel
// Valid/ready channel carrying the strict mode bit.
// ----------------------------------------------------------------------------
interface aubt_cfg_if ();
	logic valid;
	logic ready;
	logic data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== src/aubt_datapath.sv =====
// ----------------------------------------------------------------------------
// aubt_datapath: tables, unit state and result register
// Executes the controller's commands on the stream tables and unit flags.
// ----------------------------------------------------------------------------
module aubt_datapath import aubt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  pkt_t  pkt_data,
	input  logic  cfg_valid,
	input  logic  cfg_data,
	input  cmd_t  cmd,
	output stat_t stat,
	output res_t  res
);

	pkt_t pkt_q;
	logic strict_q;
	res_t res_q;

	logic [MAX_STREAMS-1:0] cm_valid_q, pd_valid_q, pr_valid_q, tr_valid_q;
	logic [LABEL_W-1:0] cm_label_q [MAX_STREAMS];
	logic [RATE_W-1:0]  cm_rate_q  [MAX_STREAMS];
	logic [FSZ_W-1:0]   cm_fsz_q   [MAX_STREAMS];
	logic [LABEL_W-1:0] pd_label_q [MAX_STREAMS];
	logic [RATE_W-1:0]  pd_rate_q  [MAX_STREAMS];
	logic [FSZ_W-1:0]   pd_fsz_q   [MAX_STREAMS];
	logic [LABEL_W-1:0] pr_label_q [MAX_STREAMS];
	logic [LABEL_W-1:0] tr_label_q [MAX_STREAMS];
	logic [TSUM_W-1:0]  tr_sum_q   [MAX_STREAMS];
	logic ipf_any_q, ipf_all_q, open_q, pbad_q;

	// lookup results
	logic pd_hit, pd_free_ok, cm_hit, pr_hit, pr_free_ok, tr_hit, tr_free_ok;
	logic [IDX_W-1:0] pd_hit_idx, pd_free_idx, pr_free_idx, tr_hit_idx, tr_free_idx;
	logic [CNT_W-1:0] npend, ncomm, nref, npres;
	logic configured, prof_bad, trunc_ok, is_frame;
	logic [TSUM_W:0]   tr_sum_wide;
	logic [TSUM_W-1:0] tr_sum_new;

	// close report
	logic cm_found, tr_found, timing_mixed, trunc_mixed;
	logic [IDX_W-1:0] cm_first, tr_first;
	logic [RATE_W-1:0] rep_rate;
	logic [FSZ_W-1:0]  rep_fsz, rep_dur;
	logic [TSUM_W-1:0] rep_trunc;
	logic [2:0]        rep_err;
	res_t emit_res, rep_res;

	always_comb begin
		pd_hit = 1'b0; pd_hit_idx = '0; pd_free_ok = 1'b0; pd_free_idx = '0;
		cm_hit = 1'b0; pr_hit = 1'b0; pr_free_ok = 1'b0; pr_free_idx = '0;
		tr_hit = 1'b0; tr_hit_idx = '0; tr_free_ok = 1'b0; tr_free_idx = '0;
		for (int i = MAX_STREAMS - 1; i >= 0; i--) begin
			if (pd_valid_q[i] && pd_label_q[i] == pkt_q.packet_label) begin
				pd_hit = 1'b1; pd_hit_idx = IDX_W'(i);
			end
			if (!pd_valid_q[i]) begin
				pd_free_ok = 1'b1; pd_free_idx = IDX_W'(i);
			end
			if (cm_valid_q[i] && cm_label_q[i] == pkt_q.packet_label) cm_hit = 1'b1;
			if (pr_valid_q[i] && pr_label_q[i] == pkt_q.packet_label) pr_hit = 1'b1;
			if (!pr_valid_q[i]) begin
				pr_free_ok = 1'b1; pr_free_idx = IDX_W'(i);
			end
			if (tr_valid_q[i] && tr_label_q[i] == pkt_q.packet_label) begin
				tr_hit = 1'b1; tr_hit_idx = IDX_W'(i);
			end
			if (!tr_valid_q[i]) begin
				tr_free_ok = 1'b1; tr_free_idx = IDX_W'(i);
			end
		end
		npend      = CNT_W'($countones(pd_valid_q));
		ncomm      = CNT_W'($countones(cm_valid_q));
		nref       = (npend != '0) ? npend : ncomm;
		configured = (npend != '0) ? pd_hit : cm_hit;
		npres      = CNT_W'($countones(pr_valid_q)) + CNT_W'(pr_free_ok);
		is_frame   = (pkt_q.packet_kind == KIND_FRAME);
		prof_bad   = !(pkt_q.cfg_profile inside {[PROFILE_LOW:PROFILE_HIGH]});
		trunc_ok   = pkt_q.trunc_active && (pd_hit || (npend == '0 && cm_hit));
		tr_sum_wide = (tr_hit ? {1'b0, tr_sum_q[tr_hit_idx]} : '0)
			+ (TSUM_W+1)'(pkt_q.trunc_count);
		tr_sum_new = tr_sum_wide[TSUM_W] ? TRUNC_MAX : tr_sum_wide[TSUM_W-1:0];

		stat.close_before = (pkt_q.packet_kind == KIND_SYNC && open_q)
			|| (is_frame && configured && pr_hit);
		stat.close_after  = is_frame && configured && !pr_hit && (npres == nref);
	end

	// close report over the committed table and the truncation sums
	always_comb begin
		cm_found = 1'b0; cm_first = '0; tr_found = 1'b0; tr_first = '0;
		timing_mixed = 1'b0; trunc_mixed = 1'b0;
		for (int i = 0; i < MAX_STREAMS; i++) begin
			if (cm_valid_q[i] && (!cm_found || cm_label_q[i] < cm_label_q[cm_first])) begin
				cm_found = 1'b1; cm_first = IDX_W'(i);
			end
			if (tr_valid_q[i] && (!tr_found || tr_label_q[i] < tr_label_q[tr_first])) begin
				tr_found = 1'b1; tr_first = IDX_W'(i);
			end
		end
		rep_rate  = cm_found ? cm_rate_q[cm_first] : '0;
		rep_fsz   = cm_found ? cm_fsz_q[cm_first] : '0;
		rep_trunc = tr_found ? tr_sum_q[tr_first] : '0;
		for (int i = 0; i < MAX_STREAMS; i++) begin
			if (cm_valid_q[i] && (cm_rate_q[i] != rep_rate || cm_fsz_q[i] != rep_fsz))
				timing_mixed = 1'b1;
			if (tr_valid_q[i] && tr_sum_q[i] != rep_trunc) trunc_mixed = 1'b1;
		end
		rep_dur = ({1'b0, rep_fsz} > rep_trunc) ? FSZ_W'(TSUM_W'(rep_fsz) - rep_trunc) : '0;
		if (pbad_q)                       rep_err = ERR_PROFILE;
		else if (ipf_any_q && !ipf_all_q) rep_err = ERR_IPF;
		else if (!cm_found)               rep_err = ERR_NOCONFIG;
		else if (timing_mixed)            rep_err = ERR_TIMING;
		else if (trunc_mixed)             rep_err = ERR_TRUNC;
		else                              rep_err = ERR_NONE;

		rep_res = '0;
		rep_res.verdict       = cmd.early ? VERD_BEFORE : VERD_AFTER;
		rep_res.last          = !cmd.early;
		rep_res.violation     = (cmd.early && is_frame) ? VIOL_REPEAT : VIOL_NONE;
		rep_res.fatal         = strict_q && (rep_res.violation != VIOL_NONE);
		rep_res.unit_rate     = rep_rate;
		rep_res.unit_duration = rep_dur;
		rep_res.unit_ipf      = ipf_all_q;
		rep_res.unit_error    = rep_err;

		emit_res = '0;
		emit_res.last    = 1'b1;
		emit_res.verdict = VERD_APPEND;
		case (pkt_q.packet_kind)
			KIND_CONFIG: begin
				if (pd_hit) emit_res.violation = VIOL_DUP;
			end
			KIND_FRAME: begin
				if (!configured) begin
					emit_res.verdict   = VERD_DISCARD;
					emit_res.violation = VIOL_NOCFG;
				end
			end
			default: ;
		endcase
		emit_res.fatal = strict_q && (emit_res.violation != VIOL_NONE);
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strict_q   <= 1'b0;
			cm_valid_q <= '0;
			pd_valid_q <= '0;
			pr_valid_q <= '0;
			tr_valid_q <= '0;
			ipf_any_q  <= 1'b0;
			ipf_all_q  <= 1'b1;
			open_q     <= 1'b0;
			pbad_q     <= 1'b0;
		end else begin
			if (cfg_valid) strict_q <= cfg_data;
			if (cmd.commit && npend != '0) cm_valid_q <= pd_valid_q;
			if (cmd.report) begin
				pd_valid_q <= '0;
				pr_valid_q <= '0;
				tr_valid_q <= '0;
				ipf_any_q  <= 1'b0;
				ipf_all_q  <= 1'b1;
				open_q     <= 1'b0;
				pbad_q     <= 1'b0;
			end
			if (cmd.apply) begin
				case (pkt_q.packet_kind)
					KIND_CONFIG: begin
						open_q <= 1'b1;
						if (prof_bad) pbad_q <= 1'b1;
						if (!pd_hit && pd_free_ok) pd_valid_q[pd_free_idx] <= 1'b1;
					end
					KIND_FRAME: begin
						if (!configured) begin
							pd_valid_q <= '0;
							pr_valid_q <= '0;
							tr_valid_q <= '0;
							ipf_any_q  <= 1'b0;
							ipf_all_q  <= 1'b1;
							open_q     <= 1'b0;
							pbad_q     <= 1'b0;
						end else begin
							open_q <= 1'b1;
							if (pr_free_ok) pr_valid_q[pr_free_idx] <= 1'b1;
							if (pkt_q.frame_ipf) ipf_any_q <= 1'b1;
							else ipf_all_q <= 1'b0;
						end
					end
					KIND_TRUNC: begin
						open_q <= 1'b1;
						if (trunc_ok && !tr_hit && tr_free_ok) tr_valid_q[tr_free_idx] <= 1'b1;
					end
					default: open_q <= 1'b1;
				endcase
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.load) pkt_q <= pkt_data;
		if (cmd.commit && npend != '0) begin
			cm_label_q <= pd_label_q;
			cm_rate_q  <= pd_rate_q;
			cm_fsz_q   <= pd_fsz_q;
		end
		if (cmd.apply) begin
			res_q <= emit_res;
			case (pkt_q.packet_kind)
				KIND_CONFIG: begin
					if (pd_hit || pd_free_ok) begin
						pd_label_q[pd_hit ? pd_hit_idx : pd_free_idx] <= pkt_q.packet_label;
						pd_rate_q[pd_hit ? pd_hit_idx : pd_free_idx]  <= pkt_q.cfg_sample_rate;
						pd_fsz_q[pd_hit ? pd_hit_idx : pd_free_idx]   <= pkt_q.cfg_frame_size;
					end
				end
				KIND_FRAME: begin
					if (configured && pr_free_ok) pr_label_q[pr_free_idx] <= pkt_q.packet_label;
				end
				KIND_TRUNC: begin
					if (trunc_ok && (tr_hit || tr_free_ok)) begin
						tr_label_q[tr_hit ? tr_hit_idx : tr_free_idx] <= pkt_q.packet_label;
						tr_sum_q[tr_hit ? tr_hit_idx : tr_free_idx]   <= tr_sum_new;
					end
				end
				default: ;
			endcase
		end
		if (cmd.report) res_q <= rep_res;
	end

	assign res = res_q;

endmodule

// ===== src/aubt_ctrl.sv =====
// ----------------------------------------------------------------------------
// aubt_ctrl: sequencing controller
// Steps each packet through decide, commit, report and result beats.
// ----------------------------------------------------------------------------
module aubt_ctrl import aubt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	ctl_state_t state_q, state_d;
	logic more_q, more_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			more_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			more_q  <= more_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		more_d    = more_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECIDE;
				end
			end
			ST_DECIDE: begin
				if (stat.close_before) begin
					cmd.commit = 1'b1;
					state_d    = ST_REP_BEFORE;
				end else begin
					cmd.apply = 1'b1;
					more_d    = 1'b0;
					state_d   = stat.close_after ? ST_COMMIT : ST_OUT;
				end
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = ST_REP_AFTER;
			end
			ST_REP_BEFORE: begin
				cmd.report = 1'b1;
				cmd.early  = 1'b1;
				more_d     = 1'b1;
				state_d    = ST_OUT;
			end
			ST_REP_AFTER: begin
				cmd.report = 1'b1;
				more_d     = 1'b0;
				state_d    = ST_OUT;
			end
			ST_OUT: begin
				out_valid = 1'b1;
				if (out_ready) state_d = more_q ? ST_DECIDE : ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("input taken while result pending");
	a_accept_decide: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_DECIDE) else $error("accept not decided");
	a_before_more: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_REP_BEFORE |=> state_q == ST_OUT && more_q)
		else $error("close-before result lost its follow-up");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !more_q |=> in_ready) else $error("final beat not idle");
`endif

endmodule

// ===== src/access_unit_boundary_tracker_top.sv =====
// ----------------------------------------------------------------------------
// access_unit_boundary_tracker_top: access unit boundary tracker
// Groups audio-stream packet descriptors into access units and reports each
// closed unit's rate, duration, IPF flag and consistency error.
//
//   channel  dir  beat
//   pkt_in   in   one packet descriptor
//   res_out  out  one result item (one or two per packet)
//   cfg      in   strict mode bit, taken in any cycle
//
// A packet occupies the block from acceptance until its final result beat is
// taken. Plain packets pass through accept, decide and result. A close after
// the packet adds commit and report steps. A close before it folds the commit
// into the decide step and adds report, a result beat and a second decide
// pass, and commit and report again when the packet then closes the new unit.
// Reset clears all tables and flags at once; a stalled result holds in the
// output register.
// ----------------------------------------------------------------------------
module access_unit_boundary_tracker_top import aubt_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	aubt_pkt_if.sink   pkt_in,
	aubt_res_if.source res_out,
	aubt_cfg_if.sink   cfg
);

	cmd_t  cmd;
	stat_t stat;
	res_t  res;

	// strict mode write is a single flop; never back-pressure it
	assign cfg.ready = 1'b1;

	aubt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pkt_in.valid),
		.in_ready  (pkt_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	aubt_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_data  (pkt_in.data),
		.cfg_valid (cfg.valid),
		.cfg_data  (cfg.data),
		.cmd       (cmd),
		.stat      (stat),
		.res       (res)
	);

	// drive result payload from the datapath's output register
	assign res_out.data = res;

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench of the access unit boundary tracker
// Drives packet descriptors with random gaps, predicts every result beat with
// its own model of the unit grouping, and checks each beat field by field.
// ----------------------------------------------------------------------------
module tb import aubt_pkg::*; ();

	localparam int LIMIT_CYCLES = 400000;
	localparam int HOLD_CYCLES  = 300;
	localparam int ITEM_TARGET  = 550;

	localparam logic [2:0] KIND_OTHER   = 3'd4;
	localparam logic [2:0] KIND_UNKNOWN = 3'd7;

	typedef struct {
		bit              v;
		bit [LABEL_W-1:0] l;
		bit [RATE_W-1:0]  r;
		bit [FSZ_W-1:0]   f;
	} cfg_ent_t;

	logic clk;
	logic arst_n;

	aubt_pkt_if pkt_ch ();
	aubt_res_if res_ch ();
	aubt_cfg_if cfg_ch ();

	access_unit_boundary_tracker_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pkt_in  (pkt_ch),
		.res_out (res_ch),
		.cfg     (cfg_ch)
	);

	// model state of the tracker
	cfg_ent_t         committed[MAX_STREAMS];
	cfg_ent_t         staged[MAX_STREAMS];
	bit               seen_v[MAX_STREAMS];
	bit [LABEL_W-1:0] seen_l[MAX_STREAMS];
	bit               cut_v[MAX_STREAMS];
	bit [LABEL_W-1:0] cut_l[MAX_STREAMS];
	bit [TSUM_W-1:0]  cut_sum[MAX_STREAMS];
	bit               any_ipf, all_ipf, in_unit, bad_prof;
	bit               strict;

	res_t due_results[$];
	int   n_items, n_beats, n_closes, n_discards, fails, cycles;
	bit   quiet;      // no random gaps on either side
	bit   hold_req;   // ask the receiver for one long hold-off

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- model
	function automatic void queue_beat(res_t r);
		due_results.insert(due_results.size(), r);
	endfunction

	function automatic int find_entry(bit in_staged, bit [LABEL_W-1:0] lbl);
		for (int i = 0; i < MAX_STREAMS; i++) begin
			if (in_staged && staged[i].v && staged[i].l == lbl) return i;
			if (!in_staged && committed[i].v && committed[i].l == lbl) return i;
		end
		return -1;
	endfunction

	function automatic int count_entries(bit in_staged);
		int n;
		n = 0;
		for (int i = 0; i < MAX_STREAMS; i++)
			n += in_staged ? staged[i].v : committed[i].v;
		return n;
	endfunction

	function automatic void clear_unit();
		for (int i = 0; i < MAX_STREAMS; i++) begin
			staged[i] = '{default: 0};
			seen_v[i] = 0;
			seen_l[i] = 0;
			cut_v[i] = 0;
			cut_l[i] = 0;
			cut_sum[i] = 0;
		end
		any_ipf = 0;
		all_ipf = 1;
		in_unit = 0;
		bad_prof = 0;
	endfunction

	function automatic res_t plain_beat(logic [1:0] verd, logic [1:0] viol);
		res_t r;
		r = '0;
		r.verdict = verd;
		r.violation = viol;
		r.fatal = (viol != VIOL_NONE) && strict;
		return r;
	endfunction

	// commit staged configs and build the closed-unit report
	function automatic res_t close_report(logic [1:0] verd, logic [1:0] viol);
		res_t r;
		int first, tfirst;
		bit [RATE_W-1:0] rate;
		bit [FSZ_W-1:0] fsz;
		bit [TSUM_W-1:0] cut;
		bit mixed_time, mixed_cut;
		first = -1; tfirst = -1; rate = 0; fsz = 0; cut = 0;
		mixed_time = 0; mixed_cut = 0;
		if (count_entries(1) > 0) committed = staged;
		for (int i = 0; i < MAX_STREAMS; i++)
			if (committed[i].v && (first < 0 || committed[i].l < committed[first].l))
				first = i;
		if (first >= 0) begin
			rate = committed[first].r;
			fsz = committed[first].f;
			for (int i = 0; i < MAX_STREAMS; i++)
				if (committed[i].v && (committed[i].r != rate || committed[i].f != fsz))
					mixed_time = 1;
		end
		for (int i = 0; i < MAX_STREAMS; i++)
			if (cut_v[i] && (tfirst < 0 || cut_l[i] < cut_l[tfirst])) tfirst = i;
		if (tfirst >= 0) begin
			cut = cut_sum[tfirst];
			for (int i = 0; i < MAX_STREAMS; i++)
				if (cut_v[i] && cut_sum[i] != cut) mixed_cut = 1;
		end
		r = plain_beat(verd, viol);
		r.unit_rate = rate;
		r.unit_duration = (fsz > cut) ? FSZ_W'(fsz - cut) : '0;
		r.unit_ipf = all_ipf;
		if (bad_prof)               r.unit_error = ERR_PROFILE;
		else if (any_ipf && !all_ipf) r.unit_error = ERR_IPF;
		else if (first < 0)         r.unit_error = ERR_NOCONFIG;
		else if (mixed_time)        r.unit_error = ERR_TIMING;
		else if (mixed_cut)         r.unit_error = ERR_TRUNC;
		else                        r.unit_error = ERR_NONE;
		n_closes++;
		clear_unit();
		return r;
	endfunction

	// returns 0 when the label already has a frame in the open unit
	function automatic bit frame_arrives(bit [LABEL_W-1:0] lbl, bit ipf, output res_t r);
		int nref, nseen, slot;
		bit known;
		nseen = 0; slot = -1;
		r = '0;
		if (count_entries(1) > 0) begin
			known = find_entry(1, lbl) >= 0;
			nref = count_entries(1);
		end else begin
			known = find_entry(0, lbl) >= 0;
			nref = count_entries(0);
		end
		if (!known) begin
			clear_unit();
			n_discards++;
			r = plain_beat(VERD_DISCARD, VIOL_NOCFG);
			return 1;
		end
		for (int i = 0; i < MAX_STREAMS; i++) begin
			if (seen_v[i]) begin
				if (seen_l[i] == lbl) return 0;
				nseen++;
			end else if (slot < 0) slot = i;
		end
		if (slot >= 0) begin
			seen_v[slot] = 1;
			seen_l[slot] = lbl;
			nseen++;
		end
		in_unit = 1;
		if (ipf) any_ipf = 1;
		else all_ipf = 0;
		r = (nseen == nref) ? close_report(VERD_AFTER, VIOL_NONE)
			: plain_beat(VERD_APPEND, VIOL_NONE);
		return 1;
	endfunction

	function automatic void track_packet(pkt_t p);
		res_t r;
		int k;
		bit [TSUM_W:0] sum;
		logic [1:0] viol;
		case (p.packet_kind)
			KIND_SYNC: begin
				if (in_unit) queue_beat(close_report(VERD_BEFORE, VIOL_NONE));
				in_unit = 1;
				queue_beat(plain_beat(VERD_APPEND, VIOL_NONE));
			end
			KIND_CONFIG: begin
				in_unit = 1;
				viol = VIOL_NONE;
				if (p.cfg_profile < PROFILE_LOW || p.cfg_profile > PROFILE_HIGH) bad_prof = 1;
				k = find_entry(1, p.packet_label);
				if (k >= 0) viol = VIOL_DUP;
				else
					for (int i = 0; i < MAX_STREAMS && k < 0; i++)
						if (!staged[i].v) k = i;
				if (k >= 0)
					staged[k] = '{1, p.packet_label, p.cfg_sample_rate, p.cfg_frame_size};
				queue_beat(plain_beat(VERD_APPEND, viol));
			end
			KIND_FRAME: begin
				if (frame_arrives(p.packet_label, p.frame_ipf, r)) queue_beat(r);
				else begin
					queue_beat(close_report(VERD_BEFORE, VIOL_REPEAT));
					void'(frame_arrives(p.packet_label, p.frame_ipf, r));
					queue_beat(r);
				end
			end
			KIND_TRUNC: begin
				in_unit = 1;
				if (p.trunc_active && (find_entry(1, p.packet_label) >= 0 ||
						(count_entries(1) == 0 && find_entry(0, p.packet_label) >= 0))) begin
					k = -1;
					for (int i = 0; i < MAX_STREAMS; i++)
						if (cut_v[i] && cut_l[i] == p.packet_label) k = i;
					for (int i = 0; i < MAX_STREAMS && k < 0; i++)
						if (!cut_v[i]) begin
							k = i;
							cut_v[i] = 1;
							cut_l[i] = p.packet_label;
							cut_sum[i] = 0;
						end
					if (k >= 0) begin
						sum = cut_sum[k] + p.trunc_count;
						cut_sum[k] = (sum > TRUNC_MAX) ? TRUNC_MAX : sum[TSUM_W-1:0];
					end
				end
				queue_beat(plain_beat(VERD_APPEND, VIOL_NONE));
			end
			default: begin
				in_unit = 1;
				queue_beat(plain_beat(VERD_APPEND, VIOL_NONE));
			end
		endcase
		due_results[due_results.size()-1].last = 1'b1;
	endfunction

	// ---------------------------------------------------------------- drivers
	// send one descriptor after a random gap; predict at the accepting edge
	task automatic send_pkt(pkt_t p);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap > 0) begin
			pkt_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pkt_ch.data <= p;
		pkt_ch.valid <= 1'b1;
		@(posedge clk);
		while (!pkt_ch.ready) @(posedge clk);
		track_packet(p);
		n_items++;
	endtask

	function automatic pkt_t mk_pkt(logic [2:0] kind, int lbl);
		pkt_t p;
		p = '0;
		p.packet_kind = kind;
		p.packet_label = LABEL_W'(lbl);
		return p;
	endfunction

	task automatic send_cfg(int lbl, int rate, int fsz, int prof);
		pkt_t p;
		p = mk_pkt(KIND_CONFIG, lbl);
		p.cfg_sample_rate = RATE_W'(rate);
		p.cfg_frame_size = FSZ_W'(fsz);
		p.cfg_profile = PROF_W'(prof);
		send_pkt(p);
	endtask

	task automatic send_frame(int lbl, bit ipf);
		pkt_t p;
		p = mk_pkt(KIND_FRAME, lbl);
		p.frame_ipf = ipf;
		send_pkt(p);
	endtask

	task automatic send_trunc(int lbl, bit act, int cnt);
		pkt_t p;
		p = mk_pkt(KIND_TRUNC, lbl);
		p.trunc_active = act;
		p.trunc_count = TCNT_W'(cnt);
		send_pkt(p);
	endtask

	// drain all expected beats, then write the strict mode bit
	task automatic set_strict(bit val);
		pkt_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		cfg_ch.data <= val;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		strict = val;
	endtask

	// receiver: fresh stall after every beat, plus one long hold on request
	initial begin
		int stall;
		res_ch.ready <= 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		res_ch.ready <= 1'b1;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 0;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_ch.ready <= 1'b1;
			end else if (res_ch.valid && res_ch.ready) begin
				stall = quiet ? 0 : $urandom_range(0, 6);
				if (stall > 0) begin
					res_ch.ready <= 1'b0;
					repeat (stall) @(posedge clk);
					res_ch.ready <= 1'b1;
				end
			end
		end
	end

	// ---------------------------------------------------------------- checker
	task automatic chk_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
			fails++;
		end
	endtask

	always @(posedge clk) begin
		res_t e, a;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			a = res_ch.data;
			n_beats++;
			if (due_results.size() == 0) begin
				$display("%0t: unexpected result beat %h", $time, a);
				fails++;
			end else begin
				e = due_results[0];
				due_results.delete(0);
				chk_field("verdict", e.verdict, a.verdict);
				chk_field("last", e.last, a.last);
				chk_field("violation", e.violation, a.violation);
				chk_field("fatal", e.fatal, a.fatal);
				chk_field("unit_rate", e.unit_rate, a.unit_rate);
				chk_field("unit_duration", e.unit_duration, a.unit_duration);
				chk_field("unit_ipf", e.unit_ipf, a.unit_ipf);
				chk_field("unit_error", e.unit_error, a.unit_error);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("%0t: timeout with %0d beats outstanding", $time, due_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests
	// frames with no config anywhere, empty units, unknown kinds
	task automatic test_empty_units();
		send_frame(5, 1);
		send_pkt(mk_pkt(KIND_SYNC, 0));
		send_pkt(mk_pkt(KIND_SYNC, 0));
		send_trunc(5, 1, 100);
		send_pkt(mk_pkt(KIND_OTHER, 1023));
		send_pkt(mk_pkt(KIND_UNKNOWN, 0));
		send_pkt(mk_pkt(KIND_SYNC, 0));
	endtask

	// extreme fields, duplicate config, truncation cases, repeated frame label
	task automatic test_config_cases();
		send_cfg(0, 24'hFFFFFF, 16'hFFFF, 8'h0B);
		send_cfg(1023, 0, 0, 8'h14);
		send_cfg(0, 24'hFFFFFF, 16'hFFFF, 8'h0B);
		send_trunc(0, 1, 8191);
		send_trunc(1023, 0, 8191);
		send_trunc(5, 1, 8191);
		send_frame(0, 1);
		send_frame(0, 0);
		send_frame(1023, 0);
		send_cfg(7, 48000, 1024, 8'h0A);
		send_cfg(8, 48000, 1024, 8'hFF);
		send_frame(7, 1);
		send_frame(8, 1);
		send_frame(500, 0);
		send_cfg(9, 44100, 960, 8'h15);
		send_frame(9, 0);
	endtask

	// nine distinct configs overflow the table; the ninth is not recorded
	task automatic test_table_full();
		for (int i = 0; i < MAX_STREAMS + 1; i++) send_cfg(100 + i, 32000, 2048, 8'h10);
		for (int i = 0; i < MAX_STREAMS + 1; i++) send_frame(100 + i, 1);
	endtask

	// push one label's truncation sum past its ceiling
	task automatic test_trunc_saturation();
		send_cfg(3, 96000, 16'hFFFF, 8'h0C);
		send_cfg(4, 96000, 16'hFFFF, 8'h0C);
		for (int i = 0; i < 17; i++) send_trunc(3, 1, 8191);
		send_trunc(4, 1, 1);
		send_frame(3, 0);
		send_frame(4, 0);
	endtask

	// violations with strict mode on, then back off
	task automatic test_strict_mode();
		set_strict(1'b1);
		send_cfg(11, 48000, 1024, 8'h0B);
		send_cfg(11, 48000, 1024, 8'h0B);
		send_frame(11, 1);
		send_frame(600, 1);
		send_cfg(12, 48000, 1024, 8'h12);
		send_frame(12, 0);
		send_frame(12, 1);
		send_frame(12, 1);
		set_strict(1'b0);
	endtask

	task automatic send_noise();
		pkt_t p;
		logic [95:0] noise;
		noise = {$urandom, $urandom, $urandom};
		p = noise[$bits(pkt_t)-1:0];
		p.packet_kind = 3'($urandom_range(0, 7));
		send_pkt(p);
	endtask

	// one mostly well-formed unit with random content
	task automatic send_unit();
		int nl, base, rate, fsz, prof;
		bit new_cfg, ipf;
		nl = $urandom_range(1, 3);
		case ($urandom_range(0, 5))
			0: base = 0;
			1: base = 1021;
			default: base = $urandom_range(0, 30);
		endcase
		new_cfg = $urandom_range(0, 9) < 7;
		rate = $urandom_range(0, 24'hFFFFFF);
		fsz = $urandom_range(0, 16'hFFFF);
		ipf = 1'($urandom);
		if ($urandom_range(0, 1)) send_pkt(mk_pkt(KIND_SYNC, $urandom_range(0, 1023)));
		if (new_cfg)
			for (int i = 0; i < nl; i++) begin
				prof = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
					: $urandom_range(PROFILE_LOW, PROFILE_HIGH);
				if ($urandom_range(0, 4) == 0) begin
					rate = $urandom_range(0, 24'hFFFFFF);
					fsz = $urandom_range(0, 16'hFFFF);
				end
				send_cfg(base + i, rate, fsz, prof);
				if ($urandom_range(0, 19) == 0) send_cfg(base + i, rate, fsz, prof);
			end
		for (int i = 0; i < nl; i++)
			if ($urandom_range(0, 2) == 0)
				send_trunc(base + i, $urandom_range(0, 5) != 0, $urandom_range(0, 8191));
		if ($urandom_range(0, 5) == 0) send_noise();
		for (int i = 0; i < nl; i++) begin
			if ($urandom_range(0, 9) == 0) ipf = !ipf;
			send_frame(base + i, ipf);
			if ($urandom_range(0, 24) == 0) send_frame(base + i, ipf);
		end
	endtask

	task automatic test_random();
		int stretch;
		stretch = 0;
		while (n_items < ITEM_TARGET - 40) begin
			// random stretches with and without gaps
			if (stretch == 0) begin
				quiet = $urandom_range(0, 3) == 0;
				stretch = $urandom_range(3, 10);
			end
			stretch--;
			if ($urandom_range(0, 7) == 0) send_noise();
			else send_unit();
		end
		quiet = 0;
	endtask

	// receiver holds off while the sender keeps offering; the block backs up
	task automatic test_backpressure();
		quiet = 1;
		hold_req = 1;
		repeat (12) send_unit();
		quiet = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		pkt_ch.valid <= 1'b0;
		pkt_ch.data <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= 1'b0;
		quiet = 0;
		hold_req = 0;
		strict = 0;
		for (int i = 0; i < MAX_STREAMS; i++) committed[i] = '{default: 0};
		clear_unit();
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		test_empty_units();
		test_config_cases();
		test_table_full();
		test_trunc_saturation();
		test_strict_mode();
		test_random();
		set_strict(1'b1);
		test_backpressure();
		test_random();
		set_strict(1'b0);

		pkt_ch.valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d packet descriptors and checked %0d result beats.", n_items, n_beats);
		$display("Units closed: %0d, units discarded: %0d, strict mode on and off.",
			n_closes, n_discards);
		if (fails == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
src/aubt_pkg.sv
src/aubt_pkt_if.sv
src/aubt_res_if.sv
src/aubt_cfg_if.sv
src/aubt_datapath.sv
src/aubt_ctrl.sv
src/access_unit_boundary_tracker_top.sv
tb/tb.sv
